[src/mfde_pkg.sv]
package mfde_pkg;

  localparam int PANEL_WIDTH_DEF  = 400;
  localparam int PANEL_HEIGHT_DEF = 300;
  localparam int ROW_BYTES_DEF    = 50;

  localparam logic [3:0] OP_FILL   = 4'd0;
  localparam logic [3:0] OP_PIXEL  = 4'd1;
  localparam logic [3:0] OP_HLINE  = 4'd2;
  localparam logic [3:0] OP_VLINE  = 4'd3;
  localparam logic [3:0] OP_LINE   = 4'd4;
  localparam logic [3:0] OP_RECT   = 4'd5;
  localparam logic [3:0] OP_FRECT  = 4'd6;
  localparam logic [3:0] OP_AALINE = 4'd7;
  localparam logic [3:0] OP_READ   = 4'd8;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_SWEEP = 2'd1;
  localparam logic [1:0] WR_RMW   = 2'd2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] span_width;
    logic [15:0] span_height;
    logic        ink;
    logic [8:0]  read_row;
    logic [5:0]  read_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] done_opcode;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       sweep_step;
    logic       sweep_zero;
    logic [1:0] wr_kind;
    logic       rd_read;
    logic       latch_cand;
    logic       walk_step;
    logic       wu_setup;
    logic       div_step;
    logic       wu_init;
    logic       capture_read;
  } dp_cmd_t;

  typedef struct packed {
    logic       cand_ok;
    logic       walk_last;
    logic       sweep_last;
    logic       div_last;
    logic [3:0] opcode;
    logic [7:0] read_data;
  } dp_sts_t;

  // 4x4 ordered dither matrix
  function automatic logic [3:0] bayer(input logic [1:0] y2, input logic [1:0] x2);
    logic [3:0] b;
    b = 4'd0;
    case ({y2, x2})
      4'h0: b = 4'd0;  4'h1: b = 4'd8;  4'h2: b = 4'd2;  4'h3: b = 4'd10;
      4'h4: b = 4'd12; 4'h5: b = 4'd4;  4'h6: b = 4'd14; 4'h7: b = 4'd6;
      4'h8: b = 4'd3;  4'h9: b = 4'd11; 4'hA: b = 4'd1;  4'hB: b = 4'd9;
      4'hC: b = 4'd15; 4'hD: b = 4'd7;  4'hE: b = 4'd13; 4'hF: b = 4'd5;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

[src/mfde_datapath.sv]
module mfde_datapath #(
  parameter int PANEL_WIDTH  = mfde_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfde_pkg::PANEL_HEIGHT_DEF,
  parameter int ROW_BYTES    = mfde_pkg::ROW_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mfde_pkg::in_item_t in_data,
  input  mfde_pkg::dp_cmd_t  cmd,
  output mfde_pkg::dp_sts_t  sts
);

  localparam int DEPTH  = PANEL_HEIGHT * ROW_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // frame store
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;
  logic wr_en;

  mfde_pkg::in_item_t item_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0] mask_r;
  logic [7:0] res_data_r;

  // scan walker
  logic [9:0] px_r;
  logic [8:0] py_r;
  logic [1:0] pass_r;
  logic x_fix, y_fix;
  logic [15:0] x_val, y_val, x_len, y_len;
  logic [17:0] sc_x, sc_y;
  logic span_ok, last_x, last_y, pass_end, scan_last;

  // line walker
  logic [15:0] bx_r, by_r;
  logic signed [20:0] bdx_r, bdy_r, err_r, e2, err_nxt;
  logic bsxn_r, bsyn_r;
  logic [15:0] in_adx, in_ady;
  logic c1, c2, bres_last;

  // antialiased walker
  logic [15:0] wadx, wady, a0, b0, a1, b1, nu0, nv0, nu1, nv1, wmag;
  logic wsteep, wswap;
  logic signed [16:0] wdy;
  logic steep_r, wneg_r;
  logic [15:0] u0_r, v0_r, u1_r, v1_r, wdx_r;
  logic [31:0] div_sh_r;
  logic [15:0] rem_r;
  logic [4:0] div_cnt_r;
  logic [16:0] div_t;
  logic div_ge;
  logic [16:0] gmag;
  logic signed [17:0] grad_r;
  logic signed [33:0] intery_r;
  logic [16:0] u_r;
  logic [1:0] wph_r;
  logic [17:0] iy, iy1, wu_u, wu_v, wx, wy;
  logic [16:0] cov;
  logic [15:0] thr;
  logic wu_last;

  logic [17:0] cx, cy;
  logic in_panel, cand_ok, walk_last;
  logic [ADDR_W-1:0] cand_addr, read_addr;
  logic rd_ok;

  function automatic logic [4:0] bayer_thr(input logic [1:0] y2, input logic [1:0] x2);
    return {mfde_pkg::bayer(y2, x2), 1'b1};
  endfunction

  // scan configuration per opcode and rectangle side
  always_comb begin
    x_fix = 1'b0;
    y_fix = 1'b0;
    x_val = item_r.x_start;
    y_val = item_r.y_start;
    x_len = item_r.span_width;
    y_len = item_r.span_height;
    case (item_r.opcode)
      mfde_pkg::OP_PIXEL: begin
        x_fix = 1'b1;
        y_fix = 1'b1;
      end
      mfde_pkg::OP_HLINE: y_fix = 1'b1;
      mfde_pkg::OP_VLINE: x_fix = 1'b1;
      mfde_pkg::OP_RECT: begin
        case (pass_r)
          2'd0: y_fix = 1'b1;
          2'd1: begin
            y_fix = 1'b1;
            y_val = item_r.y_start + item_r.span_height - 16'd1;
          end
          2'd2: x_fix = 1'b1;
          default: begin
            x_fix = 1'b1;
            x_val = item_r.x_start + item_r.span_width - 16'd1;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign sc_x = x_fix ? {2'b0, x_val} : {8'b0, px_r};
  assign sc_y = y_fix ? {2'b0, y_val} : {9'b0, py_r};
  assign span_ok = (x_fix | (({6'b0, px_r} - x_val) < x_len))
                 & (y_fix | (({7'b0, py_r} - y_val) < y_len));
  assign last_x = x_fix | (px_r == 10'(PANEL_WIDTH - 1));
  assign last_y = y_fix | (py_r == 9'(PANEL_HEIGHT - 1));
  assign pass_end = last_x & last_y;
  assign scan_last = pass_end & !((item_r.opcode == mfde_pkg::OP_RECT) && (pass_r != 2'd3));

  // line stepping
  assign in_adx = (in_data.x_end > in_data.x_start) ? in_data.x_end - in_data.x_start
                                                    : in_data.x_start - in_data.x_end;
  assign in_ady = (in_data.y_end > in_data.y_start) ? in_data.y_end - in_data.y_start
                                                    : in_data.y_start - in_data.y_end;
  assign e2 = err_r <<< 1;
  assign c1 = (e2 >= bdy_r);
  assign c2 = (e2 <= bdx_r);
  assign err_nxt = err_r + (c1 ? bdy_r : 21'sd0) + (c2 ? bdx_r : 21'sd0);
  assign bres_last = (bx_r == item_r.x_end) && (by_r == item_r.y_end);

  // antialiased setup: steep test and left-to-right ordering
  always_comb begin
    wadx = (item_r.x_end > item_r.x_start) ? item_r.x_end - item_r.x_start
                                           : item_r.x_start - item_r.x_end;
    wady = (item_r.y_end > item_r.y_start) ? item_r.y_end - item_r.y_start
                                           : item_r.y_start - item_r.y_end;
    wsteep = wady > wadx;
    a0 = wsteep ? item_r.y_start : item_r.x_start;
    b0 = wsteep ? item_r.x_start : item_r.y_start;
    a1 = wsteep ? item_r.y_end : item_r.x_end;
    b1 = wsteep ? item_r.x_end : item_r.y_end;
    wswap = a0 > a1;
    nu0 = wswap ? a1 : a0;
    nv0 = wswap ? b1 : b0;
    nu1 = wswap ? a0 : a1;
    nv1 = wswap ? b0 : b1;
    wdy = $signed({1'b0, nv1}) - $signed({1'b0, nv0});
    wmag = wdy[16] ? 16'(-wdy) : wdy[15:0];
  end

  // restoring divider, one quotient bit a cycle
  assign div_t = {rem_r, div_sh_r[31]};
  assign div_ge = div_t >= {1'b0, wdx_r};
  assign gmag = (wdx_r == 16'd0) ? 17'h10000 : div_sh_r[16:0];

  assign iy = intery_r[33:16];
  assign iy1 = iy + 18'd1;

  always_comb begin
    wu_u = {1'b0, u_r};
    wu_v = iy;
    cov = 17'h08000;
    case (wph_r)
      2'd0: begin
        wu_u = {2'b0, u0_r};
        wu_v = {2'b0, v0_r};
      end
      2'd1: begin
        wu_u = {2'b0, u1_r};
        wu_v = {2'b0, v1_r};
      end
      2'd2: cov = 17'h10000 - {1'b0, intery_r[15:0]};
      default: begin
        wu_v = iy1;
        cov = {1'b0, intery_r[15:0]};
      end
    endcase
    wx = steep_r ? wu_v : wu_u;
    wy = steep_r ? wu_u : wu_v;
    thr = {bayer_thr(wy[1:0], wx[1:0]), 11'b0};
  end

  assign wu_last = ((wph_r == 2'd1) && (wdx_r <= 16'd1))
                || ((wph_r == 2'd3) && (u_r == ({1'b0, u1_r} - 17'd1)));

  // candidate pixel of the running command
  always_comb begin
    cx = sc_x;
    cy = sc_y;
    cand_ok = span_ok;
    walk_last = scan_last;
    case (item_r.opcode)
      mfde_pkg::OP_LINE: begin
        cx = {2'b0, bx_r};
        cy = {2'b0, by_r};
        cand_ok = 1'b1;
        walk_last = bres_last;
      end
      mfde_pkg::OP_AALINE: begin
        cx = wx;
        cy = wy;
        cand_ok = cov > {1'b0, thr};
        walk_last = wu_last;
      end
      default: ;
    endcase
  end

  assign in_panel = (cx < 18'(PANEL_WIDTH)) && (cy < 18'(PANEL_HEIGHT))
                 && (cx[17:3] < 15'(ROW_BYTES));
  assign cand_addr = ADDR_W'({15'b0, cy[8:0]} * 24'(ROW_BYTES) + 24'(cx[9:3]));
  assign read_addr = ADDR_W'({15'b0, item_r.read_row} * 24'(ROW_BYTES)
                             + 24'(item_r.read_column));
  assign rd_ok = ({1'b0, item_r.read_row} < 10'(PANEL_HEIGHT))
              && ({2'b0, item_r.read_column} < 8'(ROW_BYTES));

  assign rd_addr = cmd.rd_read ? read_addr : cand_addr;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = addr_r;
    wr_data = item_r.ink ? (rdata_r & ~mask_r) : (rdata_r | mask_r);
    case (cmd.wr_kind)
      mfde_pkg::WR_SWEEP: begin
        wr_en = 1'b1;
        wr_addr = sweep_r;
        wr_data = (cmd.sweep_zero || item_r.ink) ? 8'h00 : 8'hFF;
      end
      mfde_pkg::WR_RMW: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.load) begin
      sweep_r <= '0;
    end else if (cmd.sweep_step) begin
      sweep_r <= sweep_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      px_r <= '0;
      py_r <= '0;
      pass_r <= '0;
      res_data_r <= '0;
      bx_r <= in_data.x_start;
      by_r <= in_data.y_start;
      bdx_r <= $signed({5'b0, in_adx});
      bdy_r <= -$signed({5'b0, in_ady});
      err_r <= $signed({5'b0, in_adx}) - $signed({5'b0, in_ady});
      bsxn_r <= !(in_data.x_start < in_data.x_end);
      bsyn_r <= !(in_data.y_start < in_data.y_end);
    end else if (cmd.walk_step) begin
      if (pass_end) begin
        px_r <= '0;
        py_r <= '0;
        pass_r <= pass_r + 2'd1;
      end else if (last_x) begin
        px_r <= '0;
        py_r <= py_r + 9'd1;
      end else begin
        px_r <= px_r + 10'd1;
      end
      if (c1) begin
        bx_r <= bsxn_r ? bx_r - 16'd1 : bx_r + 16'd1;
      end
      if (c2) begin
        by_r <= bsyn_r ? by_r - 16'd1 : by_r + 16'd1;
      end
      err_r <= err_nxt;
    end
    if (cmd.capture_read) begin
      res_data_r <= rd_ok ? rdata_r : 8'h00;
    end
    if (cmd.latch_cand) begin
      addr_r <= cand_addr;
      mask_r <= 8'h80 >> cx[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wu_setup) begin
      steep_r <= wsteep;
      u0_r <= nu0;
      v0_r <= nv0;
      u1_r <= nu1;
      v1_r <= nv1;
      wdx_r <= nu1 - nu0;
      wneg_r <= wdy[16];
      div_sh_r <= {wmag, 16'b0};
      rem_r <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? 16'(div_t - {1'b0, wdx_r}) : div_t[15:0];
      div_sh_r <= {div_sh_r[30:0], div_ge};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
    if (cmd.wu_init) begin
      grad_r <= wneg_r ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
      intery_r <= $signed({2'b0, v0_r, 16'b0})
                + 34'(wneg_r ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag}));
      u_r <= {1'b0, u0_r} + 17'd1;
      wph_r <= 2'd0;
    end else if (cmd.walk_step) begin
      case (wph_r)
        2'd0: wph_r <= 2'd1;
        2'd1: wph_r <= 2'd2;
        2'd2: wph_r <= 2'd3;
        default: begin
          wph_r <= 2'd2;
          u_r <= u_r + 17'd1;
          intery_r <= intery_r + 34'(grad_r);
        end
      endcase
    end
  end

  assign sts.cand_ok = cand_ok & in_panel;
  assign sts.walk_last = walk_last;
  assign sts.sweep_last = (sweep_r == ADDR_W'(DEPTH - 1));
  assign sts.div_last = (div_cnt_r == 5'd31);
  assign sts.opcode = item_r.opcode;
  assign sts.read_data = res_data_r;

endmodule

[src/mfde_ctrl.sv]
module mfde_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_opcode,
  output logic                out_valid,
  input  logic                out_stall,
  output mfde_pkg::out_item_t out_data,
  output mfde_pkg::dp_cmd_t   cmd,
  input  mfde_pkg::dp_sts_t   sts
);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_FILL     = 4'd2;
  localparam logic [3:0] ST_WALK     = 4'd3;
  localparam logic [3:0] ST_RMW      = 4'd4;
  localparam logic [3:0] ST_WU_SETUP = 4'd5;
  localparam logic [3:0] ST_DIV      = 4'd6;
  localparam logic [3:0] ST_WU_INIT  = 4'd7;
  localparam logic [3:0] ST_READ     = 4'd8;
  localparam logic [3:0] ST_READ_CAP = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  mfde_pkg::out_item_t out_data_r;
  logic out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.wr_kind = mfde_pkg::WR_SWEEP;
        cmd.sweep_zero = 1'b1;
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_opcode == mfde_pkg::OP_FILL) begin
            state_nxt = ST_FILL;
          end else if (in_opcode inside {mfde_pkg::OP_PIXEL, mfde_pkg::OP_HLINE,
                                         mfde_pkg::OP_VLINE, mfde_pkg::OP_LINE,
                                         mfde_pkg::OP_RECT, mfde_pkg::OP_FRECT}) begin
            state_nxt = ST_WALK;
          end else if (in_opcode == mfde_pkg::OP_AALINE) begin
            state_nxt = ST_WU_SETUP;
          end else if (in_opcode == mfde_pkg::OP_READ) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FILL: begin
        cmd.wr_kind = mfde_pkg::WR_SWEEP;
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        if (sts.cand_ok) begin
          cmd.latch_cand = 1'b1;
          state_nxt = ST_RMW;
        end else if (sts.walk_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_RMW: begin
        cmd.wr_kind = mfde_pkg::WR_RMW;
        if (sts.walk_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WU_SETUP: begin
        cmd.wu_setup = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_WU_INIT;
        end
      end
      ST_WU_INIT: begin
        cmd.wu_init = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_READ: begin
        cmd.rd_read = 1'b1;
        state_nxt = ST_READ_CAP;
      end
      ST_READ_CAP: begin
        cmd.capture_read = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.read_data <= sts.read_data;
      out_data_r.done_opcode <= sts.opcode;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

[src/mono_framebuffer_draw_engine.sv]
// Drawing engine over an on-chip 1 bit per pixel framebuffer (PANEL_HEIGHT rows of
// ROW_BYTES bytes, msb is the leftmost pixel, 1 is white). Each input item is one
// command and yields exactly one result item carrying the opcode and, for a read,
// the stored byte. After reset the block first clears the store, one byte a cycle,
// and takes no item until that is done. Commands then run one at a time; the frame
// store, with one read and one write port, sets the pace. Fill sweeps every byte of
// the store. Horizontal lines visit every panel column, vertical lines every panel
// row, outline rectangles every column on their two rows and every row on their two
// columns, and filled rectangles every panel pixel, not only those in the span. A
// plain line is walked one Bresenham step at a time. The antialiased line first
// runs setup and a bit-serial gradient divide, then tests two candidates per
// column. Every pixel actually drawn adds a read-modify-write step. A read passes
// through a read state and then a capture state. The result sits in an output
// register, so the next item is taken while it waits.
module mono_framebuffer_draw_engine #(
  parameter int PANEL_WIDTH  = mfde_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfde_pkg::PANEL_HEIGHT_DEF,
  parameter int ROW_BYTES    = mfde_pkg::ROW_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfde_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mfde_pkg::out_item_t out_data
);

  // command and status between sequencer and pixel datapath
  mfde_pkg::dp_cmd_t cmd;
  mfde_pkg::dp_sts_t sts;

  // sequencer: reset clear, per-opcode flow, result register
  mfde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: pixel walkers, divider, frame store
  mfde_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .ROW_BYTES    (ROW_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule
